### src/swm_pkg.sv
package swm_pkg;

  localparam int TABLE_DEPTH = 16;
  localparam int ID_BITS     = 16;

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);
  localparam int SUM_W = $clog2(255 * TABLE_DEPTH + 1);

  // Fixed field widths of the stream words.
  localparam int CID_W      = 16;
  localparam int WGT_W      = 8;
  localparam int STATUS_W   = 2;
  localparam int OSUM_W     = 12;
  localparam int OCNT_W     = 5;
  localparam int IN_DATA_W  = 24;
  localparam int OUT_DATA_W = 48;

  localparam logic OP_SET    = 1'b0;
  localparam logic OP_LOOKUP = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_ID = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic load;
    logic scan_step;
    logic edit;
    logic sum_step;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    logic             scan_done;
    logic             sum_done;
    logic [CNT_W-1:0] count;
  } stat_t;

  // Output word, most significant field first.
  typedef struct packed {
    logic [3:0]          pad;
    logic [CID_W-1:0]    main_id;
    logic                has_main;
    logic [OCNT_W-1:0]   entry_count;
    logic [OSUM_W-1:0]   weight_sum;
    logic [WGT_W-1:0]    entry_weight;
    logic [STATUS_W-1:0] status;
  } result_t;

endpackage

### src/sorted_weight_map_with_totals.sv
// An accepted word passes the scan, edit, sum and done states before its result is loaded
// into the output register; the scan stops at the slot.
// A new word is taken only after the last one's result is loaded; a finished result waits in the
// output register while the next word is already accepted.
// Reset (rst_ni low, asynchronous): controller idle, output empty, table emptied
// (count zero); table contents are not cleared.
module sorted_weight_map_with_totals (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             s_axis_tvalid_i,
  output logic                             s_axis_tready_o,
  // [15:0] community_id, [23:16] new_weight
  input  logic [swm_pkg::IN_DATA_W-1:0]    s_axis_tdata_i,
  // [0] op
  input  logic                             s_axis_tuser_i,
  output logic                             m_axis_tvalid_o,
  input  logic                             m_axis_tready_i,
  // [1:0] status, [9:2] entry_weight, [21:10] weight_sum, [26:22] entry_count,
  // [27] has_main, [43:28] main_id, [47:44] zero
  output logic [swm_pkg::OUT_DATA_W-1:0]   m_axis_tdata_o
);

  swm_pkg::cmd_t    cmd;
  swm_pkg::stat_t   st;
  swm_pkg::result_t res;

  swm_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_ready_o (s_axis_tready_o),
    .out_valid_o(m_axis_tvalid_o),
    .out_ready_i(m_axis_tready_i),
    .st_i       (st),
    .cmd_o      (cmd)
  );

  swm_dp u_dp (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cmd_i         (cmd),
    .op_i          (s_axis_tuser_i),
    .community_id_i(s_axis_tdata_i[15:0]),
    .new_weight_i  (s_axis_tdata_i[23:16]),
    .st_o          (st),
    .res_o         (res)
  );

  assign m_axis_tdata_o = res;

`ifndef ASSERT_OFF
  // One word at a time: after an accept the input side stays closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid_i && s_axis_tready_o |=> !s_axis_tready_o)
    else $error("input accepted while a word is in progress");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    st.count <= swm_pkg::CNT_W'(swm_pkg::TABLE_DEPTH))
    else $error("entry count exceeds table depth");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o && (res.status == swm_pkg::ST_FULL)
      |-> res.entry_count == swm_pkg::OCNT_W'(swm_pkg::TABLE_DEPTH))
    else $error("full status reported on a table that is not full");
`endif

endmodule

### src/swm_ctrl.sv
module swm_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  input  swm_pkg::stat_t st_i,
  output swm_pkg::cmd_t  cmd_o
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_SCAN = 3'd1;
  localparam logic [2:0] S_EDIT = 3'd2;
  localparam logic [2:0] S_SUM  = 3'd3;
  localparam logic [2:0] S_DONE = 3'd4;

  logic [2:0] state_q, state_d;
  logic       out_valid_q, out_valid_d;

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    in_ready_o = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        in_ready_o = 1'b1;
        if (in_valid_i) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (st_i.scan_done) begin
          state_d = S_EDIT;
        end
      end
      S_EDIT: begin
        cmd_o.edit = 1'b1;
        state_d    = S_SUM;
      end
      S_SUM: begin
        cmd_o.sum_step = 1'b1;
        if (st_i.sum_done) begin
          state_d = S_DONE;
        end
      end
      S_DONE: begin
        // The result waits here until the output register is free.
        if (!out_valid_q || out_ready_i) begin
          cmd_o.out_load = 1'b1;
          state_d        = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if (cmd_o.out_load) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;

endmodule

### src/swm_dp.sv
module swm_dp (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  swm_pkg::cmd_t                 cmd_i,
  input  logic                          op_i,
  input  logic [swm_pkg::CID_W-1:0]     community_id_i,
  input  logic [swm_pkg::WGT_W-1:0]     new_weight_i,
  output swm_pkg::stat_t                st_o,
  output swm_pkg::result_t              res_o
);

  localparam int D     = swm_pkg::TABLE_DEPTH;
  localparam int IDB   = swm_pkg::ID_BITS;
  localparam int CW    = swm_pkg::CNT_W;
  localparam int WW    = swm_pkg::WGT_W;

  logic [IDB-1:0] ids_q [D];
  logic [WW-1:0]  wts_q [D];
  logic [IDB-1:0] nxt_id [D];
  logic [WW-1:0]  nxt_w  [D];
  logic [IDB-1:0] prv_id [D];
  logic [WW-1:0]  prv_w  [D];

  logic                       op_q;
  logic [IDB-1:0]             key_q;
  logic [WW-1:0]              w_q;
  logic [CW-1:0]              cnt_q;
  logic [CW-1:0]              k_q;
  logic [CW-1:0]              slot_q;
  logic                       found_q;
  logic                       present_q;
  logic [swm_pkg::STATUS_W-1:0] status_q;
  logic [swm_pkg::SUM_W-1:0]  sum_q;
  logic [WW-1:0]              ew_q;
  logic [IDB-1:0]             main_id_q;
  logic [WW-1:0]              main_w_q;
  swm_pkg::result_t           res_q;

  logic [IDB-1:0] rd_id;
  logic [WW-1:0]  rd_w;
  logic           scan_done, sum_done;
  logic           bad_id, is_set, do_del, do_upd, do_ins, is_full;

  assign rd_id = ids_q[k_q[swm_pkg::IDX_W-1:0]];
  assign rd_w  = wts_q[k_q[swm_pkg::IDX_W-1:0]];

  assign scan_done = found_q || (k_q == cnt_q);
  assign sum_done  = (k_q == cnt_q);

  assign bad_id  = (key_q == '0);
  assign is_set  = !bad_id && (op_q == swm_pkg::OP_SET);
  assign do_del  = is_set && (w_q == '0) && present_q;
  assign do_upd  = is_set && (w_q != '0) && present_q;
  assign is_full = is_set && (w_q != '0) && !present_q && (cnt_q >= CW'(D));
  assign do_ins  = is_set && (w_q != '0) && !present_q && (cnt_q < CW'(D));

  // Each slot sees its neighbors so that an insert or a removal shifts the
  // whole tail in the single edit step.
  for (genvar g = 0; g < D; g++) begin : g_slot
    if (g < D - 1) begin : g_nxt
      assign nxt_id[g] = ids_q[g+1];
      assign nxt_w[g]  = wts_q[g+1];
    end else begin : g_nxt_last
      assign nxt_id[g] = ids_q[g];
      assign nxt_w[g]  = wts_q[g];
    end
    if (g > 0) begin : g_prv
      assign prv_id[g] = ids_q[g-1];
      assign prv_w[g]  = wts_q[g-1];
    end else begin : g_prv_first
      assign prv_id[g] = ids_q[g];
      assign prv_w[g]  = wts_q[g];
    end

    always_ff @(posedge clk_i) begin
      if (cmd_i.edit) begin
        if (do_del && (CW'(g) >= slot_q) && (CW'(g + 1) < cnt_q)) begin
          ids_q[g] <= nxt_id[g];
          wts_q[g] <= nxt_w[g];
        end else if (do_ins && (CW'(g) > slot_q) && (CW'(g) <= cnt_q)) begin
          ids_q[g] <= prv_id[g];
          wts_q[g] <= prv_w[g];
        end else if (do_ins && (CW'(g) == slot_q)) begin
          ids_q[g] <= key_q;
          wts_q[g] <= w_q;
        end else if (do_upd && (CW'(g) == slot_q)) begin
          wts_q[g] <= w_q;
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else if (cmd_i.edit) begin
      if (do_del) begin
        cnt_q <= cnt_q - CW'(1);
      end else if (do_ins) begin
        cnt_q <= cnt_q + CW'(1);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      op_q      <= op_i;
      key_q     <= IDB'(community_id_i);
      w_q       <= new_weight_i;
      k_q       <= '0;
      found_q   <= 1'b0;
      present_q <= 1'b0;
      slot_q    <= cnt_q;
    end else if (cmd_i.scan_step && !scan_done) begin
      // First slot whose id is not below the key.
      if (rd_id >= key_q) begin
        found_q   <= 1'b1;
        slot_q    <= k_q;
        present_q <= (rd_id == key_q);
      end
      k_q <= k_q + CW'(1);
    end else if (cmd_i.edit) begin
      k_q       <= '0;
      sum_q     <= '0;
      ew_q      <= '0;
      main_id_q <= '0;
      main_w_q  <= '0;
      if (bad_id) begin
        status_q <= swm_pkg::ST_BAD_ID;
      end else if (is_full) begin
        status_q <= swm_pkg::ST_FULL;
      end else begin
        status_q <= swm_pkg::ST_OK;
      end
    end else if (cmd_i.sum_step && !sum_done) begin
      sum_q <= sum_q + swm_pkg::SUM_W'(rd_w);
      if (!bad_id && (rd_id == key_q)) begin
        ew_q <= rd_w;
      end
      // Strictly greater keeps the smallest id on a tie.
      if (rd_w > main_w_q) begin
        main_w_q  <= rd_w;
        main_id_q <= rd_id;
      end
      k_q <= k_q + CW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      res_q.pad          <= '0;
      res_q.main_id      <= swm_pkg::CID_W'(main_id_q);
      res_q.has_main     <= (cnt_q != '0);
      res_q.entry_count  <= swm_pkg::OCNT_W'(cnt_q);
      res_q.weight_sum   <= swm_pkg::OSUM_W'(sum_q);
      res_q.entry_weight <= ew_q;
      res_q.status       <= status_q;
    end
  end

  assign st_o.scan_done = scan_done;
  assign st_o.sum_done  = sum_done;
  assign st_o.count     = cnt_q;
  assign res_o          = res_q;

endmodule

### tb/tb_sorted_weight_map_with_totals.sv
module tb_sorted_weight_map_with_totals;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 10;
  localparam int CYCLE_LIMIT = 500000;
  localparam int POOL_SIZE   = 48;
  localparam int RANDOM_WORDS = 700;
  localparam int DIR_ROWS    = 11;

  typedef struct packed {
    logic             op;
    logic [15:0]      cid;
    logic [7:0]       wgt;
    logic             typed;
    swm_pkg::result_t res;
  } dir_row_t;

  logic                           clk_i           = 1'b0;
  logic                           rst_ni          = 1'b0;
  logic                           s_axis_tvalid_i = 1'b0;
  logic                           s_axis_tready_o;
  logic [swm_pkg::IN_DATA_W-1:0]  s_axis_tdata_i  = '0;
  logic                           s_axis_tuser_i  = 1'b0;
  logic                           m_axis_tvalid_o;
  logic                           m_axis_tready_i = 1'b0;
  logic [swm_pkg::OUT_DATA_W-1:0] m_axis_tdata_o;

  // Shadow copy of the table, kept sorted by id like the block's own.
  logic [15:0] shadow_ids  [swm_pkg::TABLE_DEPTH];
  logic [7:0]  shadow_wgts [swm_pkg::TABLE_DEPTH];
  int          shadow_count = 0;

  swm_pkg::result_t pending_results[$];
  logic [15:0]      id_pool[POOL_SIZE];
  dir_row_t         dir_rows[DIR_ROWS];
  int               mismatches   = 0;
  int               results_seen = 0;
  int               cycle_count  = 0;

  sorted_weight_map_with_totals uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_axis_tvalid_i),
    .s_axis_tready_o (s_axis_tready_o),
    .s_axis_tdata_i  (s_axis_tdata_i),
    .s_axis_tuser_i  (s_axis_tuser_i),
    .m_axis_tvalid_o (m_axis_tvalid_o),
    .m_axis_tready_i (m_axis_tready_i),
    .m_axis_tdata_o  (m_axis_tdata_o)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("tb: failure");
      $finish;
    end
  end

  function automatic swm_pkg::result_t typed_result(logic [1:0] st, logic [7:0] ew,
                                                    logic [11:0] sum, logic [4:0] cnt,
                                                    logic [15:0] heaviest);
    swm_pkg::result_t r;
    r              = '0;
    r.status       = st;
    r.entry_weight = ew;
    r.weight_sum   = sum;
    r.entry_count  = cnt;
    r.has_main     = (cnt != 0);
    r.main_id      = heaviest;
    return r;
  endfunction

  // Applies one word to the shadow table and returns the result it must produce.
  function automatic swm_pkg::result_t apply_to_table(logic op, logic [15:0] cid,
                                                      logic [7:0] wgt);
    swm_pkg::result_t r;
    int               slot;
    bit               hit;
    logic [7:0]       best_w;
    r = '0;
    if (cid == '0) begin
      r.status = swm_pkg::ST_BAD_ID;
    end else if (op == swm_pkg::OP_SET) begin
      slot = 0;
      while (slot < shadow_count && shadow_ids[slot] < cid) slot++;
      hit = (slot < shadow_count) && (shadow_ids[slot] == cid);
      if (wgt == '0) begin
        if (hit) begin
          for (int k = slot; k < shadow_count - 1; k++) begin
            shadow_ids[k]  = shadow_ids[k + 1];
            shadow_wgts[k] = shadow_wgts[k + 1];
          end
          shadow_count--;
        end
      end else if (hit) begin
        shadow_wgts[slot] = wgt;
      end else if (shadow_count >= swm_pkg::TABLE_DEPTH) begin
        r.status = swm_pkg::ST_FULL;
      end else begin
        for (int k = shadow_count; k > slot; k--) begin
          shadow_ids[k]  = shadow_ids[k - 1];
          shadow_wgts[k] = shadow_wgts[k - 1];
        end
        shadow_ids[slot]  = cid;
        shadow_wgts[slot] = wgt;
        shadow_count++;
      end
    end
    best_w = '0;
    for (int k = 0; k < shadow_count; k++) begin
      r.weight_sum += swm_pkg::OSUM_W'(shadow_wgts[k]);
      if (cid != '0 && shadow_ids[k] == cid) r.entry_weight = shadow_wgts[k];
      // Strictly greater keeps the smallest id among equal weights.
      if (shadow_wgts[k] > best_w) begin
        best_w    = shadow_wgts[k];
        r.main_id = shadow_ids[k];
      end
    end
    r.entry_count = swm_pkg::OCNT_W'(shadow_count);
    r.has_main    = (shadow_count != 0);
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 50) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  function automatic logic [7:0] pick_weight();
    int r;
    r = $urandom_range(0, 99);
    if (r < 10) return 8'hFF;
    if (r < 15) return 8'h01;
    return 8'($urandom_range(1, 255));
  endfunction

  function automatic logic [15:0] any_stored_id();
    return shadow_ids[$urandom_range(0, shadow_count - 1)];
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(input logic op, input logic [15:0] cid, input logic [7:0] wgt,
                           input logic typed, input swm_pkg::result_t typed_res);
    swm_pkg::result_t predicted;
    s_axis_tdata_i  <= {wgt, cid};
    s_axis_tuser_i  <= op;
    s_axis_tvalid_i <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready_o);
    predicted = apply_to_table(op, cid, wgt);
    pending_results.insert(pending_results.size(), typed ? typed_res : predicted);
    @(negedge clk_i);
  endtask

  task automatic sender_gap(input int gap);
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
  endtask

  always @(posedge clk_i) begin : result_check
    swm_pkg::result_t got;
    swm_pkg::result_t want;
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got = swm_pkg::result_t'(m_axis_tdata_o);
      results_seen++;
      if (pending_results.size() == 0) begin
        mismatches++;
        if (mismatches <= 10) $display("unexpected result word %h", got);
      end else begin
        want = pending_results.pop_front();
        if (got !== want) begin
          mismatches++;
          if (mismatches <= 10) begin
            $display("mismatch (exp/got): status %0d/%0d weight %0d/%0d sum %0d/%0d",
                     want.status, got.status, want.entry_weight, got.entry_weight,
                     want.weight_sum, got.weight_sum);
            $display("  count %0d/%0d has_main %0d/%0d main_id %h/%h pad %h/%h",
                     want.entry_count, got.entry_count, want.has_main, got.has_main,
                     want.main_id, got.main_id, want.pad, got.pad);
          end
        end
      end
    end
  end

  // Result side: random back-pressure, calm stretches, and one long hold
  // that lets the block fill up and stall its input.
  initial begin : result_sink
    int stall_left;
    bit long_hold_done;
    stall_left     = 0;
    long_hold_done = 0;
    forever begin
      @(negedge clk_i);
      if (!long_hold_done && results_seen >= 150) begin
        long_hold_done = 1;
        stall_left     = 300;
      end
      if (stall_left > 0) begin
        m_axis_tready_i <= 1'b0;
        stall_left--;
      end else begin
        m_axis_tready_i <= 1'b1;
        if (((cycle_count / 500) % 4 != 0) && $urandom_range(0, 3) == 0)
          stall_left = pick_gap();
      end
    end
  end

  initial begin : word_source
    int          r;
    bit          fill_phase;
    logic        op;
    logic [15:0] cid;
    logic [7:0]  wgt;

    id_pool[0] = 16'hFFFF;
    id_pool[1] = 16'h0001;
    for (int k = 2; k < POOL_SIZE; k++) id_pool[k] = 16'($urandom_range(1, 65535));

    dir_rows = '{
      '{swm_pkg::OP_LOOKUP, 16'h0000, 8'h00, 1'b1,
        typed_result(swm_pkg::ST_BAD_ID, 8'd0,   12'd0,   5'd0, 16'h0000)},
      '{swm_pkg::OP_SET,    16'h0000, 8'hFF, 1'b1,
        typed_result(swm_pkg::ST_BAD_ID, 8'd0,   12'd0,   5'd0, 16'h0000)},
      '{swm_pkg::OP_SET,    16'h0002, 8'h00, 1'b1,
        typed_result(swm_pkg::ST_OK,     8'd0,   12'd0,   5'd0, 16'h0000)},
      '{swm_pkg::OP_SET,    16'hFFFF, 8'hFF, 1'b1,
        typed_result(swm_pkg::ST_OK,     8'd255, 12'd255, 5'd1, 16'hFFFF)},
      '{swm_pkg::OP_SET,    16'h0001, 8'hFF, 1'b1,
        typed_result(swm_pkg::ST_OK,     8'd255, 12'd510, 5'd2, 16'h0001)},
      '{swm_pkg::OP_SET,    16'h0001, 8'h01, 1'b1,
        typed_result(swm_pkg::ST_OK,     8'd1,   12'd256, 5'd2, 16'hFFFF)},
      '{swm_pkg::OP_LOOKUP, 16'hFFFF, 8'hFF, 1'b1,
        typed_result(swm_pkg::ST_OK,     8'd255, 12'd256, 5'd2, 16'hFFFF)},
      '{swm_pkg::OP_SET,    16'h8000, 8'h00, 1'b1,
        typed_result(swm_pkg::ST_OK,     8'd0,   12'd256, 5'd2, 16'hFFFF)},
      '{swm_pkg::OP_SET,    16'hFFFF, 8'h00, 1'b1,
        typed_result(swm_pkg::ST_OK,     8'd0,   12'd1,   5'd1, 16'h0001)},
      '{swm_pkg::OP_LOOKUP, 16'h0000, 8'hAA, 1'b1,
        typed_result(swm_pkg::ST_BAD_ID, 8'd0,   12'd1,   5'd1, 16'h0001)},
      '{swm_pkg::OP_LOOKUP, 16'h0001, 8'h55, 1'b1,
        typed_result(swm_pkg::ST_OK,     8'd1,   12'd1,   5'd1, 16'h0001)}
    };

    repeat (10) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (dir_rows[i]) begin
      send_word(dir_rows[i].op, dir_rows[i].cid, dir_rows[i].wgt,
                dir_rows[i].typed, dir_rows[i].res);
      sender_gap(pick_gap());
    end

    // Fill the table: high ids land at the back, low ids at the front.
    for (int k = 1; k <= swm_pkg::TABLE_DEPTH - 1; k++) begin
      cid = (k % 2 != 0) ? 16'(16'hF000 - k * 16'h0F0F) : 16'(k * 3 + 2);
      send_word(swm_pkg::OP_SET, cid, 8'(k * 17), 1'b0, '0);
      sender_gap(pick_gap());
    end
    send_word(swm_pkg::OP_SET, 16'h7777, 8'h80, 1'b0, '0);
    send_word(swm_pkg::OP_SET, 16'h0001, 8'hFE, 1'b0, '0);
    send_word(swm_pkg::OP_SET, 16'h0001, 8'h00, 1'b0, '0);

    for (int n = 0; n < RANDOM_WORDS; n++) begin
      if (n == RANDOM_WORDS / 2) begin
        s_axis_tvalid_i <= 1'b0;
        do @(negedge clk_i); while (pending_results.size() != 0);
      end
      // Alternate between growing the table toward full and draining it.
      fill_phase = ((n / 120) % 2) == 0;
      r   = $urandom_range(0, 99);
      op  = swm_pkg::OP_SET;
      wgt = pick_weight();
      cid = id_pool[$urandom_range(0, POOL_SIZE - 1)];
      if ($urandom_range(0, 19) == 0) cid = 16'($urandom_range(0, 65535));
      if (r < 3) begin
        cid = '0;
        op  = 1'($urandom_range(0, 1));
        wgt = 8'($urandom_range(0, 255));
      end else if (r < 25) begin
        op  = swm_pkg::OP_LOOKUP;
        wgt = 8'($urandom_range(0, 255));
        if (shadow_count != 0 && $urandom_range(0, 1) == 1) cid = any_stored_id();
      end else if (fill_phase ? (r < 40) : (r < 85)) begin
        wgt = '0;
        if (shadow_count != 0 && $urandom_range(0, 4) != 0) cid = any_stored_id();
      end
      send_word(op, cid, wgt, 1'b0, '0);
      if ((n / 40) % 3 != 0) sender_gap(pick_gap());
    end
    s_axis_tvalid_i <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (60) @(posedge clk_i);
    if (mismatches == 0 && pending_results.size() == 0) begin
      $display("tb: success");
    end else begin
      $display("tb: failure");
    end
    $finish;
  end

endmodule
